// ===== rtl/core/adaptive_adpcm_dequantizer_core_macros.svh =====
// Assertion helpers for the dequantizer core.
// Each helper is disabled while reset is asserted.
`ifndef ADAPTIVE_ADPCM_DEQUANTIZER_CORE_MACROS_SVH
`define ADAPTIVE_ADPCM_DEQUANTIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define AADQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion %m failed");
// Next-cycle implication.
`define AADQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion %m failed");
`else
`define AADQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AADQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/aadq_pkg.sv =====
`default_nettype none

package aadq_pkg;

  // Default stream geometry
  localparam int NUM_BANDS_DEF    = 4;
  localparam int NUM_CHANNELS_DEF = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MU        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS      = 3'd4;

  localparam int CFG_DATA_W = 64;

  // Register reset values
  localparam logic [10:0] ALPHA_RST     = 11'd1000;
  localparam logic [10:0] ALPHA_MAX     = 11'd1024;
  localparam logic [14:0] MIN_POWER_RST = 15'd64;
  localparam logic [15:0] BITS_RST      = 16'h4444;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PWA,
    ST_PWB,
    ST_PWF,
    ST_STEP,
    ST_PRED,
    ST_WB
  } state_e;

  // Datapath commands, one per sequencer step
  typedef struct packed {
    logic load;
    logic init;
    logic diff;
    logic pwa;
    logic pwb;
    logic pwf;
    logic step;
    logic pred;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_init;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/aadq_intf.sv =====
`default_nettype none

interface aadq_item_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic              channel;
  logic [1:0]        subband;
  logic signed [7:0] code;

  modport source (output valid, func, channel, subband, code, input ready);
  modport sink   (input valid, func, channel, subband, code, output ready);
endinterface

interface aadq_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               out_channel;
  logic [1:0]         out_subband;

  modport source (output valid, sample, out_channel, out_subband, input ready);
  modport sink   (input valid, sample, out_channel, out_subband, output ready);
endinterface

interface aadq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aadq_ctrl.sv =====
`default_nettype none
`include "adaptive_adpcm_dequantizer_core_macros.svh"

module aadq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  input  wire aadq_pkg::sts_t sts_i,
  output aadq_pkg::cmd_t     cmd_o
);

  aadq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aadq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    item_ready_o = 1'b0;
    unique case (state_q)
      aadq_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = aadq_pkg::ST_CHECK;
        end
      end
      aadq_pkg::ST_CHECK: begin
        // drop streams out of range, handle init right here
        if (!sts_i.in_range) begin
          state_d = aadq_pkg::ST_IDLE;
        end else if (sts_i.is_init) begin
          cmd_o.init = 1'b1;
          state_d    = aadq_pkg::ST_IDLE;
        end else begin
          cmd_o.diff = 1'b1;
          state_d    = aadq_pkg::ST_PWA;
        end
      end
      aadq_pkg::ST_PWA: begin
        cmd_o.pwa = 1'b1;
        state_d   = aadq_pkg::ST_PWB;
      end
      aadq_pkg::ST_PWB: begin
        cmd_o.pwb = 1'b1;
        state_d   = aadq_pkg::ST_PWF;
      end
      aadq_pkg::ST_PWF: begin
        cmd_o.pwf = 1'b1;
        state_d   = aadq_pkg::ST_STEP;
      end
      aadq_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = aadq_pkg::ST_PRED;
      end
      aadq_pkg::ST_PRED: begin
        cmd_o.pred = 1'b1;
        state_d    = aadq_pkg::ST_WB;
      end
      aadq_pkg::ST_WB: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.wb = 1'b1;
          state_d  = aadq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aadq_pkg::ST_IDLE;
      end
    endcase
  end

  `AADQ_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, item_valid_i && item_ready_o, state_q == aadq_pkg::ST_CHECK)
  `AADQ_ASSERT_NEXT(a_wb_holds, clk_i, rst_ni, state_q == aadq_pkg::ST_WB && !sts_i.out_free, state_q == aadq_pkg::ST_WB)
  `AADQ_ASSERT_IMP(a_write_in_range, clk_i, rst_ni, cmd_o.init || cmd_o.wb, sts_i.in_range)

endmodule

`default_nettype wire

// ===== rtl/core/aadq_dp.sv =====
`default_nettype none
`include "adaptive_adpcm_dequantizer_core_macros.svh"

module aadq_dp #(
  parameter int NUM_BANDS    = aadq_pkg::NUM_BANDS_DEF,
  parameter int NUM_CHANNELS = aadq_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_func_i,
  input  wire logic              item_channel_i,
  input  wire logic [1:0]        item_subband_i,
  input  wire logic signed [7:0] item_code_i,
  aadq_result_if.source          result_o,
  aadq_cfg_if.sink               cfg_i,
  input  wire aadq_pkg::cmd_t    cmd_i,
  output aadq_pkg::sts_t         sts_o
);

  localparam int NSTREAMS = NUM_CHANNELS * NUM_BANDS;
  localparam int IDX_W    = (NSTREAMS > 1) ? $clog2(NSTREAMS) : 1;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Widths outside 1..8 clamp to the nearest end
  function automatic logic [3:0] clamp_bits(input logic [3:0] nib);
    if (nib == 4'd0) begin
      return 4'd1;
    end else if (nib > 4'd8) begin
      return 4'd8;
    end
    return nib;
  endfunction

  function automatic logic [14:0] step_for_bits(input logic [3:0] nib);
    logic [3:0]  b;
    logic [16:0] s;
    b = clamp_bits(nib);
    s = 17'd1 << (5'd16 - {1'b0, b});
    return (s > 17'd32767) ? 15'h7FFF : s[14:0];
  endfunction

  // Configuration registers
  logic [10:0] alpha_q;
  logic [14:0] minp_q;
  logic [63:0] phi_q;
  logic [31:0] mu_q;
  logic [15:0] bits_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= aadq_pkg::ALPHA_RST;
      minp_q  <= aadq_pkg::MIN_POWER_RST;
      phi_q   <= '0;
      mu_q    <= '0;
      bits_q  <= aadq_pkg::BITS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        aadq_pkg::CFG_ALPHA: begin
          alpha_q <= (cfg_i.data[10:0] > aadq_pkg::ALPHA_MAX) ? aadq_pkg::ALPHA_MAX
                                                              : cfg_i.data[10:0];
        end
        aadq_pkg::CFG_MIN_POWER: minp_q <= cfg_i.data[14:0];
        aadq_pkg::CFG_PHI:       phi_q  <= cfg_i.data;
        aadq_pkg::CFG_MU:        mu_q   <= cfg_i.data[31:0];
        aadq_pkg::CFG_BITS:      bits_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic              func_q;
  logic              ch_q;
  logic [1:0]        band_q;
  logic signed [7:0] code_q;
  logic [IDX_W-1:0]  idx_q;
  logic              inr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= item_func_i;
      ch_q   <= item_channel_i;
      band_q <= item_subband_i;
      code_q <= item_code_i;
      idx_q  <= IDX_W'(int'(item_channel_i) * NUM_BANDS + int'(item_subband_i));
      inr_q  <= (int'(item_channel_i) < NUM_CHANNELS) && (int'(item_subband_i) < NUM_BANDS);
    end
  end

  // Per-band factors
  logic [3:0]  bits_raw;
  logic [3:0]  bits_cl;
  logic [15:0] phi_sel;
  logic [7:0]  mu_sel;

  assign bits_raw = bits_q[{band_q, 2'b00} +: 4];
  assign bits_cl  = clamp_bits(bits_raw);
  assign phi_sel  = phi_q[{band_q, 4'b0000} +: 16];
  assign mu_sel   = mu_q[{band_q, 3'b000} +: 8];

  // Stream state
  logic signed [15:0] pred_q  [NSTREAMS];
  logic [14:0]        step_q  [NSTREAMS];
  logic [14:0]        power_q [NSTREAMS];

  logic signed [15:0] pred_rd;
  logic [14:0]        step_rd;
  logic [14:0]        power_rd;

  assign pred_rd  = pred_q[idx_q];
  assign step_rd  = step_q[idx_q];
  assign power_rd = power_q[idx_q];

  // Working registers
  logic signed [15:0] diff_q;
  logic signed [16:0] sum_q;
  logic [26:0]        acc_q;
  logic [15:0]        pw_q;
  logic [31:0]        stp_prod_q;
  logic [14:0]        stp_new_q;
  logic signed [25:0] pr_prod_q;

  logic signed [23:0] diff_prod;
  logic [15:0]        mag;
  logic [10:0]        alpha_c;
  logic [26:0]        acc_rnd;
  logic [15:0]        pw_r;
  logic [15:0]        pw_fl;
  logic [4:0]         sh;
  logic [32:0]        st_sum;
  logic [32:0]        st_sh;
  logic [14:0]        stp_new;
  logic signed [26:0] pr_sum;
  logic signed [26:0] pr_sh;
  logic signed [15:0] pred_new;
  logic [14:0]        pw_sat;

  assign diff_prod = code_q * $signed({1'b0, step_rd});
  assign mag       = diff_q[15] ? 16'(~diff_q + 16'd1) : diff_q;
  assign alpha_c   = aadq_pkg::ALPHA_MAX - alpha_q;
  assign acc_rnd   = acc_q + 27'd512;
  assign pw_r      = 16'(acc_rnd >> 10);
  assign pw_fl     = (pw_r < {1'b0, minp_q}) ? {1'b0, minp_q} : pw_r;

  assign sh        = 5'(bits_cl) + 5'd4;
  assign st_sum    = {1'b0, stp_prod_q} + (33'd1 << (sh - 5'd1));
  assign st_sh     = st_sum >> sh;
  assign stp_new   = (st_sh > 33'd32767) ? 15'h7FFF :
                     ((st_sh == 33'd0) ? 15'd1 : st_sh[14:0]);

  assign pr_sum    = 27'(pr_prod_q) + 27'sd16;
  assign pr_sh     = pr_sum >>> 5;
  assign pred_new  = sat16(32'(pr_sh));
  assign pw_sat    = (pw_q > 16'd32767) ? 15'h7FFF : pw_q[14:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      diff_q <= sat16(32'(diff_prod));
    end
    if (cmd_i.pwa) begin
      acc_q <= 27'(alpha_q) * 27'(power_rd);
      sum_q <= 17'(pred_rd) + 17'(diff_q);
    end
    if (cmd_i.pwb) begin
      acc_q <= acc_q + 27'(alpha_c) * 27'(mag);
    end
    if (cmd_i.pwf) begin
      pw_q <= pw_fl;
    end
    if (cmd_i.step) begin
      stp_prod_q <= phi_sel * pw_q;
    end
    if (cmd_i.pred) begin
      stp_new_q <= stp_new;
      pr_prod_q <= sum_q * $signed({1'b0, mu_sel});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTREAMS; i++) begin
        pred_q[i]  <= '0;
        step_q[i]  <= step_for_bits(aadq_pkg::BITS_RST[4 * (i % NUM_BANDS) +: 4]);
        power_q[i] <= aadq_pkg::MIN_POWER_RST;
      end
    end else if (cmd_i.init) begin
      pred_q[idx_q]  <= '0;
      step_q[idx_q]  <= step_for_bits(bits_raw);
      power_q[idx_q] <= minp_q;
    end else if (cmd_i.wb) begin
      pred_q[idx_q]  <= pred_new;
      step_q[idx_q]  <= stp_new_q;
      power_q[idx_q] <= pw_sat;
    end
  end

  // Output register
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               och_q;
  logic [1:0]         osb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      sample_q <= sat16(32'(sum_q));
      och_q    <= ch_q;
      osb_q    <= band_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.sample      = sample_q;
  assign result_o.out_channel = och_q;
  assign result_o.out_subband = osb_q;

  assign sts_o.in_range = inr_q;
  assign sts_o.is_init  = func_q;
  assign sts_o.out_free = !out_valid_q || result_o.ready;

  `AADQ_ASSERT_IMP(a_wb_no_overwrite, clk_i, rst_ni, cmd_i.wb, !out_valid_q || result_o.ready)
  `AADQ_ASSERT_IMP(a_step_nonzero, clk_i, rst_ni, cmd_i.wb, stp_new_q != 15'd0)
  `AADQ_ASSERT_IMP(a_power_floor, clk_i, rst_ni, cmd_i.wb, pw_q >= {1'b0, minp_q})

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_adpcm_dequantizer_core.sv =====
// A dequantize result reaches the output register through the check, power
// smoothing, step, prediction and write-back states; the write-back waits for a
// free output, and a new transaction is taken only once the sequencer is idle.
// Reset: asynchronous, active low; clears control, restores the registers and
// every stream's state at once, so the core is ready in the first cycle after.
`default_nettype none

module adaptive_adpcm_dequantizer_core #(
  parameter int NUM_BANDS    = aadq_pkg::NUM_BANDS_DEF,
  parameter int NUM_CHANNELS = aadq_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  aadq_item_if.sink      item_i,
  aadq_result_if.source  result_o,
  aadq_cfg_if.sink       cfg_i
);

  // Commands flow from the sequencer to the datapath, status flows back.
  aadq_pkg::cmd_t cmd;
  aadq_pkg::sts_t sts;

  // Sequencer: accepts one transaction in idle, then advances the datapath
  // through the difference, power smoothing, step and prediction steps, and
  // holds the write-back until the output register is free. An output result
  // still waiting does not stop the next transaction from being accepted.
  aadq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath: configuration registers, per-stream prediction, step and power,
  // the working registers between multiplies, and the output register.
  aadq_dp #(
    .NUM_BANDS    (NUM_BANDS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_func_i    (item_i.func),
    .item_channel_i (item_i.channel),
    .item_subband_i (item_i.subband),
    .item_code_i    (item_i.code),
    .result_o       (result_o),
    .cfg_i          (cfg_i),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

// ===== test/adaptive_adpcm_dequantizer_core_checker.sv =====
package aadq_tb_pkg;

  typedef enum logic {
    FUNC_DEQUANT = 1'b0,
    FUNC_INIT    = 1'b1
  } func_e;

endpackage

module adaptive_adpcm_dequantizer_core_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  aadq_item_if   item_i,
  aadq_result_if result_i,
  aadq_cfg_if    cfg_i,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import aadq_pkg::*;
  import aadq_tb_pkg::*;

  localparam int NSTREAM = NUM_BANDS_DEF * NUM_CHANNELS_DEF;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               chan;
    logic [1:0]         band;
  } sample_t;

  logic [10:0] alpha_q;
  logic [14:0] min_power_q;
  logic [63:0] phi_q;
  logic [31:0] mu_q;
  logic [15:0] bits_q;

  logic signed [15:0] pred_q  [NSTREAM];
  logic [14:0]        step_q  [NSTREAM];
  logic [14:0]        power_q [NSTREAM];

  sample_t samples_due_q[$];

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Quantizer width of a band, clamped to 1..8
  function automatic int band_width(input logic [1:0] band);
    int w;
    w = int'(bits_q[4*band +: 4]);
    if (w < 1) w = 1;
    if (w > 8) w = 8;
    return w;
  endfunction

  function automatic void init_stream(input int idx);
    int w;
    w = band_width(2'(idx % NUM_BANDS_DEF));
    pred_q[idx]  = '0;
    step_q[idx]  = ((1 << (16 - w)) > 32767) ? 15'd32767 : 15'(1 << (16 - w));
    power_q[idx] = min_power_q;
  endfunction

  // Dequantize one code, adapt the stream and return the reconstructed sample
  function automatic sample_t dequantize(input logic chan, input logic [1:0] band,
                                         input logic signed [7:0] code);
    int      idx, w;
    longint  diff, mag, pw, st, sum, pr, phi, mu;
    sample_t res;
    idx  = NUM_BANDS_DEF * int'(chan) + int'(band);
    w    = band_width(band);
    phi  = longint'(phi_q[16*band +: 16]);
    mu   = longint'(mu_q[8*band +: 8]);
    diff = sat16(longint'(code) * longint'(step_q[idx]));
    mag  = (diff < 0) ? -diff : diff;
    pw   = (longint'(alpha_q) * longint'(power_q[idx])
            + longint'(1024 - int'(alpha_q)) * mag + 512) >>> 10;
    if (pw < longint'(min_power_q)) pw = longint'(min_power_q);
    st   = (phi * pw + (longint'(1) << (w + 3))) >>> (w + 4);
    if (st == 0) st = 1;
    sum  = longint'(pred_q[idx]) + diff;
    pr   = (sum * mu + 16) >>> 5;
    pred_q[idx]  = 16'(sat16(pr));
    step_q[idx]  = (st > 32767) ? 15'd32767 : 15'(st);
    power_q[idx] = (pw > 32767) ? 15'd32767 : 15'(pw);
    res.sample = 16'(sat16(sum));
    res.chan   = chan;
    res.band   = band;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want, got;
    if (!rst_ni) begin
      alpha_q     = ALPHA_RST;
      min_power_q = MIN_POWER_RST;
      phi_q       = '0;
      mu_q        = '0;
      bits_q      = BITS_RST;
      for (int i = 0; i < NSTREAM; i++) init_stream(i);
      samples_due_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.sample = result_i.sample;
        got.chan   = result_i.out_channel;
        got.band   = result_i.out_subband;
        if (samples_due_q.size() == 0) begin
          $display("%0t: unexpected sample %0d ch %0d sb %0d",
                   $time, got.sample, got.chan, got.band);
          fail_count_o++;
        end else begin
          want = samples_due_q.pop_front();
          if (want != got) begin
            $display("%0t: expected sample %0d ch %0d sb %0d, got sample %0d ch %0d sb %0d",
                     $time, want.sample, want.chan, want.band,
                     got.sample, got.chan, got.band);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ALPHA:     alpha_q = (cfg_i.data[10:0] > ALPHA_MAX) ? ALPHA_MAX
                                                                  : cfg_i.data[10:0];
          CFG_MIN_POWER: min_power_q = cfg_i.data[14:0];
          CFG_PHI:       phi_q = cfg_i.data;
          CFG_MU:        mu_q = cfg_i.data[31:0];
          CFG_BITS:      bits_q = cfg_i.data[15:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.func == FUNC_INIT) begin
          init_stream(NUM_BANDS_DEF * int'(item_i.channel) + int'(item_i.subband));
        end else begin
          samples_due_q.push_back(dequantize(item_i.channel, item_i.subband, item_i.code));
        end
      end
      pending_o = samples_due_q.size();
    end
  end

endmodule

// ===== test/adaptive_adpcm_dequantizer_core_tb.sv =====
module adaptive_adpcm_dequantizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aadq_pkg::*;
  import aadq_tb_pkg::*;

  // Sink stall patterns for the result channel
  typedef enum int {
    RDY_OPEN,    // always ready
    RDY_COIN,    // ready half of the time
    RDY_SPARSE,  // ready now and then
    RDY_BLOCK    // held off for the whole stretch
  } rdy_mode_e;

  localparam int ITEMS_PER_PHASE = 225;
  localparam int RANDOM_PHASES   = 8;
  localparam int SETTLE_CYCLES   = 12;  // lets a trailing transaction finish

  logic clk_i = 1'b0;
  logic rst_ni;

  aadq_item_if   item_if ();
  aadq_result_if result_if ();
  aadq_cfg_if    cfg_if ();

  int fail_count;
  int pending;

  int        burst_left = 0;
  int        ready_left = 0;
  rdy_mode_e ready_mode = RDY_OPEN;

  adaptive_adpcm_dequantizer_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  adaptive_adpcm_dequantizer_core_checker dequant_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_if),
    .result_i     (result_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result sink: switch between stall patterns after a random stretch so
  // back-pressure holds the sequencer's write-back in varied ways.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = rdy_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 60);
    end
    ready_left--;
    case (ready_mode)
      RDY_OPEN:   result_if.ready <= 1'b1;
      RDY_COIN:   result_if.ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: result_if.ready <= ($urandom_range(0, 7) == 0);
      default:    result_if.ready <= 1'b0;
    endcase
  end

  // Offer one transaction in bursts; between most bursts, drop valid for a random
  // gap. Called and returns at a falling edge. Valid is left high so the next
  // transaction of a burst follows without a bubble.
  task automatic send_item(input func_e func, input logic chan, input logic [1:0] band,
                           input logic signed [7:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    item_if.valid   <= 1'b1;
    item_if.func    <= func;
    item_if.channel <= chan;
    item_if.subband <= band;
    item_if.code    <= code;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender until every sample has come out, then let an init or a
  // trailing transaction finish inside the core.
  task automatic drain_results();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write all five registers back to back, valid held high across them.
  task automatic load_settings(input logic [63:0] alpha, input logic [63:0] min_power,
                               input logic [63:0] phi, input logic [63:0] mu,
                               input logic [63:0] bits);
    logic [63:0] vals [5];
    vals[CFG_ALPHA]     = alpha;
    vals[CFG_MIN_POWER] = min_power;
    vals[CFG_PHI]       = phi;
    vals[CFG_MU]        = mu;
    vals[CFG_BITS]      = bits;
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= 3'(i);
      cfg_if.data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [63:0]       alpha_v, minp_v, phi_v, mu_v, bits_v;
    logic signed [7:0] code_v;

    item_if.valid   = 1'b0;
    item_if.func    = FUNC_DEQUANT;
    item_if.channel = 1'b0;
    item_if.subband = 2'd0;
    item_if.code    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_ALPHA;
    cfg_if.data     = '0;
    result_if.ready = 1'b0;
    rst_ni          = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: zero gains, so the step collapses to one after the
    // first sample. Hit both saturation rails and the stream init.
    send_item(FUNC_DEQUANT, 1'b0, 2'd0, 8'h7F);
    send_item(FUNC_DEQUANT, 1'b1, 2'd3, 8'h80);
    send_item(FUNC_DEQUANT, 1'b0, 2'd1, 8'h00);
    send_item(FUNC_DEQUANT, 1'b1, 2'd2, 8'hFF);
    send_item(FUNC_DEQUANT, 1'b0, 2'd0, 8'h01);
    send_item(FUNC_INIT,    1'b0, 2'd0, 8'h00);
    send_item(FUNC_DEQUANT, 1'b0, 2'd0, 8'h7F);
    drain_results();

    // Alpha beyond the top clamps, minimum floor, full step and prediction
    // gains; widths zero, one, eight and fifteen across the bands.
    load_settings(64'd2047, 64'd1, '1, 64'hFFFF_FFFF, 64'hF810);
    for (int b = 0; b < 4; b++) begin
      send_item(FUNC_INIT,    1'(b), 2'(b), 8'h00);
      send_item(FUNC_DEQUANT, 1'(b), 2'(b), 8'h7F);
      send_item(FUNC_DEQUANT, 1'(b), 2'(b), 8'h80);
    end
    drain_results();

    // No smoothing, top power floor, no gains.
    load_settings(64'd0, 64'd32767, '0, '0, 64'h1111);
    send_item(FUNC_DEQUANT, 1'b1, 2'd1, 8'h80);
    send_item(FUNC_DEQUANT, 1'b1, 2'd1, 8'h7F);
    send_item(FUNC_INIT,    1'b1, 2'd1, 8'h00);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       alpha_v = 64'd0;
        1:       alpha_v = 64'd1024;
        2:       alpha_v = 64'd2047;
        3:       alpha_v = 64'($urandom_range(0, 2047));
        default: alpha_v = 64'($urandom_range(960, 1023));
      endcase
      case ($urandom_range(0, 3))
        0:       minp_v = 64'd1;
        1:       minp_v = 64'd32767;
        2:       minp_v = 64'($urandom_range(0, 32767));
        default: minp_v = 64'($urandom_range(8, 600));
      endcase
      case ($urandom_range(0, 5))
        0:       phi_v = '1;
        1:       phi_v = '0;
        2, 3:    phi_v = {$urandom, $urandom};
        default: begin
          for (int b = 0; b < 4; b++) phi_v[16*b +: 16] = 16'($urandom_range(500, 6000));
        end
      endcase
      case ($urandom_range(0, 4))
        0:       mu_v = 64'($urandom);
        1:       mu_v = 64'hFFFF_FFFF;
        2:       mu_v = '0;
        default: begin
          mu_v = '0;
          for (int b = 0; b < 4; b++) mu_v[8*b +: 8] = 8'($urandom_range(20, 32));
        end
      endcase
      case ($urandom_range(0, 2))
        0:       bits_v = 64'($urandom_range(0, 65535));
        default: begin
          bits_v = '0;
          for (int b = 0; b < 4; b++) bits_v[4*b +: 4] = 4'($urandom_range(1, 8));
        end
      endcase
      load_settings(alpha_v, minp_v, phi_v, mu_v, bits_v);

      // Half the time restart every stream, as a decoder does on a new frame
      // layout.
      if ($urandom_range(0, 1) == 1) begin
        for (int s = 0; s < 8; s++) send_item(FUNC_INIT, 1'(s / 4), 2'(s % 4), 8'h00);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mix small codes, which let the step settle, with full-range ones.
        if ($urandom_range(0, 1) == 1) begin
          code_v = 8'($urandom_range(0, 255));
        end else begin
          code_v = 8'(int'($urandom_range(0, 8)) - 4);
        end
        if ($urandom_range(0, 13) == 0) begin
          send_item(FUNC_INIT, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), code_v);
        end else begin
          send_item(FUNC_DEQUANT, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), code_v);
        end
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal one.
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/aadq_pkg.sv
rtl/core/aadq_intf.sv
rtl/core/aadq_ctrl.sv
rtl/core/aadq_dp.sv
rtl/core/adaptive_adpcm_dequantizer_core.sv
test/adaptive_adpcm_dequantizer_core_checker.sv
test/adaptive_adpcm_dequantizer_core_tb.sv
